[rtl/vclb_pkg.sv]
`default_nettype none
package vclb_pkg;

  localparam int TAPS      = 3;
  localparam int MAX_WIDTH = 1024;
  localparam int LINES     = TAPS - 1;
  localparam int NUM_COEFF = 6;

  localparam int PIX_W     = 32;
  localparam int COEFF_W   = 16;
  localparam int FWIDTH_W  = 11;
  localparam int ROW_W     = 16;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RST  = FWIDTH_W'(1024);
  localparam logic [ROW_W-1:0]    FRAME_HEIGHT_RST = ROW_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_TAP_COEFF_0,
    REG_TAP_COEFF_1,
    REG_TAP_COEFF_2,
    REG_TAP_COEFF_3,
    REG_TAP_COEFF_4,
    REG_TAP_COEFF_5
  } cfg_reg_t;

  typedef logic [TAPS-1:0][PIX_W-1:0]        window_t;
  typedef logic [LINES-1:0][PIX_W-1:0]       lines_t;
  typedef logic [NUM_COEFF-1:0][COEFF_W-1:0] coeff_bank_t;

  // effective frame geometry and taps, as used by the datapath
  typedef struct packed {
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    coeff_bank_t      coeff;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/vclb_pix_if.sv]
`default_nettype none
interface vclb_pix_if import vclb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface
`default_nettype wire

[rtl/vclb_res_if.sv]
`default_nettype none
interface vclb_res_if import vclb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] filtered_value;
  logic             frame_last;

  modport source (output valid, output filtered_value, output frame_last, input ready);
  modport sink   (input valid, input filtered_value, input frame_last, output ready);
endinterface
`default_nettype wire

[rtl/vclb_cfg.sv]
`default_nettype none
module vclb_cfg import vclb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  logic [FWIDTH_W-1:0] frame_width_r;
  logic [ROW_W-1:0]    frame_height_r;
  coeff_bank_t         coeff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      coeff_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FWIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[ROW_W-1:0];
        REG_TAP_COEFF_0:  coeff_r[0]     <= cfg_data[COEFF_W-1:0];
        REG_TAP_COEFF_1:  coeff_r[1]     <= cfg_data[COEFF_W-1:0];
        REG_TAP_COEFF_2:  coeff_r[2]     <= cfg_data[COEFF_W-1:0];
        REG_TAP_COEFF_3:  coeff_r[3]     <= cfg_data[COEFF_W-1:0];
        REG_TAP_COEFF_4:  coeff_r[4]     <= cfg_data[COEFF_W-1:0];
        REG_TAP_COEFF_5:  coeff_r[5]     <= cfg_data[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp width to 1..MAX_WIDTH and height to at least 1
  always_comb begin
    if (frame_width_r == '0) begin
      cfg.last_col = '0;
    end else if (int'(frame_width_r) > MAX_WIDTH) begin
      cfg.last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      cfg.last_col = COL_W'(frame_width_r - FWIDTH_W'(1));
    end
    if (frame_height_r == '0) begin
      cfg.last_row = '0;
    end else begin
      cfg.last_row = frame_height_r - ROW_W'(1);
    end
    cfg.coeff = coeff_r;
  end

endmodule
`default_nettype wire

[rtl/vclb_line_mem.sv]
`default_nettype none
module vclb_line_mem import vclb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] rd_addr,
  output logic      [PIX_W-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  wire logic [PIX_W-1:0] wr_data
);

  logic [PIX_W-1:0] mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-first: a same-address write in this cycle is not seen
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[rtl/vclb_mac.sv]
`default_nettype none
module vclb_mac import vclb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        load,
  input  window_t          win,
  input  coeff_bank_t      coeff,
  output logic [PIX_W-1:0] sum
);

  window_t prod_nxt;
  window_t prod_r;

  // low 32 bits of each product; the pixel's sign does not matter there, but the coefficient is sign-extended
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      prod_nxt[i] = PIX_W'($signed(win[i]) * $signed(coeff[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum = sum + prod_r[i];
    end
  end

endmodule
`default_nettype wire

[rtl/vertical_convolution_line_buffer_unit.sv]
`default_nettype none
// an accepted beat moves through stage 1, the mac product register and the output register
// throughput: one pixel per cycle unless stalled, limited by one read and write port per memory
// rows below TAPS-1 of each frame update the line memories but produce no result beat
// reset (rst_n low, synchronous): counters, pipeline valids and config registers cleared
// to their defaults; line memory contents are undefined until written
module vertical_convolution_line_buffer_unit import vclb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  vclb_pix_if.sink                   in_ch,
  vclb_res_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  vclb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // raster position of the next input beat
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;

  // stage 1: pixel register beside the registered line memory reads
  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_produce_r;
  logic             s1_last_r;
  logic             s1_fwd_r;
  lines_t           s1_fwd_data_r;

  // stage 2: registered products inside the mac
  logic             s2_valid_r, s2_valid_nxt;
  logic             s2_last_r;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_value_r;
  logic             out_last_r;

  logic             in_acc;
  logic             s1_move, s2_move, s2_free, out_free;
  logic             end_row, end_frame;
  lines_t           rd_data;
  window_t          win;
  logic [PIX_W-1:0] mac_sum;

  // ready chain: output register, then products, then stage 1
  assign out_free = !out_valid_r || out_ch.ready;
  assign s2_move  = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || s2_move;
  // rows without a result leave stage 1 without needing a slot downstream
  assign s1_move  = s1_valid_r && (!s1_produce_r || s2_free);
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign in_acc   = in_ch.valid && in_ch.ready;

  assign end_row   = col_cnt_r >= cfg.last_col;
  assign end_frame = end_row && (row_cnt_r >= cfg.last_row);

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_acc) begin
      if (end_row) begin
        col_cnt_nxt = '0;
        if (end_frame) begin
          row_cnt_nxt = '0;
        end else begin
          row_cnt_nxt = row_cnt_r + ROW_W'(1);
        end
      end else begin
        col_cnt_nxt = col_cnt_r + COL_W'(1);
      end
    end
  end

  // vertical window: oldest line first, incoming pixel last
  // when the previous beat wrote this same column on the edge this beat read it,
  // the memory returned stale data and the captured write data is used instead
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      win[i] = s1_fwd_r ? s1_fwd_data_r[i] : rd_data[i];
    end
    win[TAPS-1] = s1_pix_r;
  end

  // one memory per stored line; on leaving stage 1 each line takes the next newer value
  for (genvar g = 0; g < LINES; g++) begin : g_line
    vclb_line_mem u_mem (
      .clk     (clk),
      .rd_en   (in_acc),
      .rd_addr (col_cnt_r),
      .rd_data (rd_data[g]),
      .wr_en   (s1_move),
      .wr_addr (s1_col_r),
      .wr_data (win[g+1])
    );
  end

  vclb_mac u_mac (
    .clk   (clk),
    .load  (s1_move && s1_produce_r),
    .win   (win),
    .coeff (cfg.coeff),
    .sum   (mac_sum)
  );

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_move);
  assign s2_valid_nxt  = (s1_move && s1_produce_r) || (s2_valid_r && !s2_move);
  assign out_valid_nxt = s2_move || (out_valid_r && !out_ch.ready);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r     <= in_ch.pixel_value;
      s1_col_r     <= col_cnt_r;
      s1_produce_r <= row_cnt_r >= ROW_W'(LINES);
      s1_last_r    <= end_frame;
      s1_fwd_r     <= s1_move && (s1_col_r == col_cnt_r);
      for (int i = 0; i < LINES; i++) begin
        s1_fwd_data_r[i] <= win[i+1];
      end
    end
    if (s1_move && s1_produce_r) begin
      s2_last_r <= s1_last_r;
    end
    if (s2_move) begin
      out_value_r <= mac_sum;
      out_last_r  <= s2_last_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_value = out_value_r;
  assign out_ch.frame_last     = out_last_r;

endmodule
`default_nettype wire

[test/vertical_convolution_line_buffer_unit_tb.sv]
`timescale 1ns / 1ps

module vertical_convolution_line_buffer_unit_tb;
  import vclb_pkg::*;

  localparam int NUM_REGS      = int'(REG_TAP_COEFF_5) + 1;
  localparam int RANDOM_PIXELS = 200;
  // idle time after the last owed beat, so beats from rows that give no result leave the pipe
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 600000;

  // one expected beat on the result channel
  typedef struct packed {
    logic [PIX_W-1:0] sum;
    logic             last;
  } filt_beat_t;

  // receiver behavior, switched at random times
  typedef enum int {
    RX_STREAM,
    RX_COIN,
    RX_STARVED,
    RX_PULSE
  } rx_mode_t;

  // tracks line memories, counters and taps of the filter and holds the sums still owed
  class vfir_scoreboard;
    logic [PIX_W-1:0]    line_mem [LINES][MAX_WIDTH];
    logic [FWIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]    height_reg;
    logic [COEFF_W-1:0]  coeff_reg [NUM_COEFF];
    int unsigned         col_cnt;
    int unsigned         row_cnt;
    filt_beat_t          owed_sums [$];
    int unsigned         mismatches;
    int unsigned         results_seen;
    int unsigned         frame_ends;

    function new();
      width_reg    = FRAME_WIDTH_RST;
      height_reg   = FRAME_HEIGHT_RST;
      foreach (coeff_reg[i]) coeff_reg[i] = '0;
      col_cnt      = 0;
      row_cnt      = 0;
      mismatches   = 0;
      results_seen = 0;
      frame_ends   = 0;
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      else if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int unsigned pixels_to_frame_end();
      int unsigned w;
      int unsigned h;
      int unsigned n;
      w = eff_width();
      h = eff_height();
      n = (col_cnt >= w - 1) ? 1 : w - col_cnt;
      if (row_cnt < h - 1) n += (h - 1 - row_cnt) * w;
      return n;
    endfunction

    function int unsigned pending();
      return owed_sums.size();
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:  width_reg = data[FWIDTH_W-1:0];
        REG_FRAME_HEIGHT: height_reg = data[ROW_W-1:0];
        default:          coeff_reg[int'(idx) - int'(REG_TAP_COEFF_0)] = data[COEFF_W-1:0];
      endcase
    endfunction

    function void take_pixel(logic [PIX_W-1:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int          t;
      logic [PIX_W-1:0] acc;
      logic [PIX_W-1:0] tap_in;
      bit          end_row;
      bit          end_frame;
      filt_beat_t  beat;
      w   = eff_width();
      h   = eff_height();
      col = col_cnt % MAX_WIDTH;
      acc = '0;
      for (t = 0; t < TAPS; t++) begin
        tap_in = (t < LINES) ? line_mem[t][col] : pix;
        acc = acc + tap_in * {{(PIX_W-COEFF_W){coeff_reg[t][COEFF_W-1]}}, coeff_reg[t]};
        if (t > 0) line_mem[t-1][col] = tap_in;
      end
      end_row   = col_cnt >= w - 1;
      end_frame = end_row && row_cnt >= h - 1;
      if (row_cnt >= LINES) begin
        beat.sum  = acc;
        beat.last = end_frame;
        owed_sums.push_back(beat);
      end
      if (end_row) begin
        col_cnt = 0;
        row_cnt = end_frame ? 0 : (row_cnt + 1) & 32'hFFFF;
      end else begin
        col_cnt++;
      end
    endfunction

    function void note_error(string msg);
      if (mismatches < 10) $display("mismatch: %s", msg);
      mismatches++;
    endfunction

    function void match_output(logic [PIX_W-1:0] sum, logic last);
      filt_beat_t want;
      results_seen++;
      if (last === 1'b1) frame_ends++;
      if (owed_sums.size() == 0) begin
        note_error($sformatf("unexpected result beat sum=%h last=%b", sum, last));
        return;
      end
      want = owed_sums.pop_front();
      if (sum !== want.sum || last !== want.last)
        note_error($sformatf("result %0d: expected sum=%h last=%b, got sum=%h last=%b",
                             results_seen, want.sum, want.last, sum, last));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  vclb_pix_if pix_bus ();
  vclb_res_if res_bus ();

  vertical_convolution_line_buffer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_bus),
    .out_ch    (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vfir_scoreboard sb;

  // register values staged for the next write pass, and which of them to write
  logic [CFG_DATA_W-1:0] reg_plan [NUM_REGS];
  logic [NUM_REGS-1:0]   plan_sel;

  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned bursts      = 0;
  int unsigned holds       = 0;
  int unsigned pixels_sent = 0;
  int unsigned reg_writes  = 0;
  int unsigned random_sent = 0;

  // pixel words at the corners of the 32-bit signed range
  logic [PIX_W-1:0] corner_pixels [12] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
    32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout: run stopped after %0d cycles, %0d result beats still owed",
             cycle_count, sb.pending());
    $display("FAIL");
    $finish;
  end

  // receiver: ready follows a mode that changes at random times
  initial begin
    rx_mode_t    rx_mode;
    int unsigned rx_left;
    logic [7:0]  rx_tick;
    rx_mode = RX_STREAM;
    rx_left = 0;
    rx_tick = '0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_STREAM:  res_bus.ready <= 1'b1;
        RX_COIN:    res_bus.ready <= 1'($urandom_range(0, 1));
        RX_STARVED: res_bus.ready <= ($urandom_range(0, 3) == 0);
        default:    res_bus.ready <= rx_tick[2];
      endcase
    end
  end

  // every result beat taken by the receiver is checked against the oldest owed sum
  always @(posedge clk) begin
    if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
      sb.match_output(res_bus.filtered_value, res_bus.frame_last);
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_coeff();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 16'h7FFF;
    else if (pick < 16) return 16'h8000;
    else if (pick < 26) return 16'($signed($urandom_range(0, 4)) - 2);
    else return CFG_DATA_W'($urandom);
  endfunction

  // frame width word; bits above the 11-bit field carry junk
  function automatic logic [CFG_DATA_W-1:0] width_word(int unsigned w);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[FWIDTH_W-1:0] = w[FWIDTH_W-1:0];
    return word;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_height();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return CFG_DATA_W'($urandom_range(3, 6));
    else if (pick < 70) return CFG_DATA_W'($urandom_range(1, 2));
    else if (pick < 75) return '0;
    else if (pick < 82) return 16'hFFFF;
    else if (pick < 92) return CFG_DATA_W'($urandom_range(7, 40));
    else return CFG_DATA_W'($urandom);
  endfunction

  // write the staged registers on back-to-back cycles, then release the port
  task automatic apply_plan();
    int r;
    for (r = 0; r < NUM_REGS; r++) begin
      if (plan_sel[r]) begin
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(r);
        cfg_data  <= reg_plan[r];
        @(posedge clk);
        sb.set_reg(cfg_reg_t'(r), reg_plan[r]);
        reg_writes++;
      end
    end
    cfg_we   <= 1'b0;
    cfg_data <= CFG_DATA_W'($urandom);
    plan_sel = '0;
  endtask

  // one pixel beat; bursts of random length with random gaps between them
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      bursts++;
      if (bursts % 16 == 5) begin
        // hold the sender until every owed result beat has come out
        pix_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        holds++;
      end else if (gap != 0) begin
        pix_bus.valid       <= 1'b0;
        pix_bus.pixel_value <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.pixel_value <= value;
    @(posedge clk);
    while (!pix_bus.ready) @(posedge clk);
    sb.take_pixel(value);
    pixels_sent++;
    burst_left--;
  endtask

  // stop sending, wait for all owed beats, then let rows with no result leave the pipe
  task automatic drain();
    pix_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned w;
    int unsigned frame_px;
    int          c;

    sb = new();
    pix_bus.valid       <= 1'b0;
    pix_bus.pixel_value <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_FRAME_WIDTH;
    cfg_data            <= '0;
    rst_n               <= 1'b0;
    plan_sel = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry (full-width lines, tall frame): set taps only, run part of the first row
    for (c = 0; c < NUM_COEFF; c++) begin
      reg_plan[int'(REG_TAP_COEFF_0) + c] = rand_coeff();
      plan_sel[int'(REG_TAP_COEFF_0) + c] = 1'b1;
    end
    apply_plan();
    repeat (MAX_WIDTH / 32) send_pixel(rand_pixel());
    drain();

    // width and height of zero act as one: the next beat closes the frame, then nothing
    reg_plan[REG_FRAME_WIDTH]  = width_word(0);
    reg_plan[REG_FRAME_HEIGHT] = '0;
    plan_sel[REG_FRAME_WIDTH]  = 1'b1;
    plan_sel[REG_FRAME_HEIGHT] = 1'b1;
    apply_plan();
    repeat (4) send_pixel(rand_pixel());
    drain();

    // corner pixels against corner taps on a 3x4 frame
    reg_plan[REG_FRAME_WIDTH]  = width_word(3);
    reg_plan[REG_FRAME_HEIGHT] = 16'd4;
    reg_plan[REG_TAP_COEFF_0]  = 16'h7FFF;
    reg_plan[REG_TAP_COEFF_1]  = 16'h8000;
    reg_plan[REG_TAP_COEFF_2]  = 16'hFFFF;
    reg_plan[REG_TAP_COEFF_3]  = 16'h0001;
    reg_plan[REG_TAP_COEFF_4]  = 16'h8000;
    reg_plan[REG_TAP_COEFF_5]  = 16'h7FFF;
    plan_sel = '1;
    apply_plan();
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    drain();

    // frame too short to fill the window: no result beats at all
    reg_plan[REG_FRAME_HEIGHT] = 16'd2;
    reg_plan[REG_TAP_COEFF_0]  = 16'hFFFF;
    reg_plan[REG_TAP_COEFF_1]  = 16'h0001;
    reg_plan[REG_TAP_COEFF_2]  = 16'h8000;
    plan_sel[REG_FRAME_HEIGHT] = 1'b1;
    plan_sel[REG_TAP_COEFF_0]  = 1'b1;
    plan_sel[REG_TAP_COEFF_1]  = 1'b1;
    plan_sel[REG_TAP_COEFF_2]  = 1'b1;
    apply_plan();
    repeat (6) send_pixel(rand_pixel());
    drain();

    // width above the line length clamps: run one full line plus a few, then
    // narrow the frame mid-row so the following rows show where the wrap fell
    reg_plan[REG_FRAME_WIDTH]  = width_word($urandom_range(MAX_WIDTH + 1, 2047));
    reg_plan[REG_FRAME_HEIGHT] = 16'hFFFF;
    for (c = 0; c < NUM_COEFF; c++) reg_plan[int'(REG_TAP_COEFF_0) + c] = rand_coeff();
    plan_sel = '1;
    apply_plan();
    k = $urandom_range(1, 6);
    repeat (MAX_WIDTH + k) send_pixel(rand_pixel());
    drain();
    reg_plan[REG_FRAME_WIDTH] = width_word(k + 1 + $urandom_range(0, 3));
    plan_sel[REG_FRAME_WIDTH] = 1'b1;
    apply_plan();

    // random segments: new settings while idle, then mostly whole frames
    while (random_sent < RANDOM_PIXELS) begin
      drain();
      plan_sel = NUM_REGS'($urandom_range(1, (1 << NUM_REGS) - 1));
      // lines only grow on the first row, so the window never reads a stale column
      if (sb.row_cnt == 0) begin
        n = $urandom_range(0, 99);
        if (n < 70) w = $urandom_range(1, 12);
        else if (n < 87) w = $urandom_range(13, 64);
        else if (n < 96) w = 0;
        else w = $urandom_range(0, 2047);
      end else begin
        w = $urandom_range(0, sb.eff_width());
      end
      reg_plan[REG_FRAME_WIDTH]  = width_word(w);
      reg_plan[REG_FRAME_HEIGHT] = rand_height();
      for (c = 0; c < NUM_COEFF; c++) reg_plan[int'(REG_TAP_COEFF_0) + c] = rand_coeff();
      apply_plan();

      if ($urandom_range(0, 99) < 75) begin
        // finish the current frame, sometimes with a couple more whole frames
        n = sb.pixels_to_frame_end();
        frame_px = sb.eff_width() * sb.eff_height();
        if (frame_px <= 120) n += $urandom_range(0, 2) * frame_px;
        if (n > 400) n = $urandom_range(1, 60);
      end else begin
        // stop somewhere inside a frame
        n = $urandom_range(1, 40);
      end
      repeat (n) begin
        send_pixel(rand_pixel());
        random_sent++;
      end
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d pixel beats, %0d result beats, %0d frame ends, %0d register writes",
             pixels_sent, sb.results_seen, sb.frame_ends, reg_writes);
    $display("widths from one column to the full %0d-pixel line, %0d sender hold-offs, %0d cycles",
             MAX_WIDTH, holds, cycle_count);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d result beats never seen", sb.mismatches, sb.pending());
      $display("FAIL");
    end
    $finish;
  end

endmodule
